FILE: hdl/dsm_pkg.sv
// ----------------------------------------------------------------------------
// dsm_pkg - shared types and constants for the dot-star pattern matcher
// Token format, item commands, state record and the star closure function.
// ----------------------------------------------------------------------------
package dsm_pkg;

  localparam int MAX_TOKENS = 16;
  localparam int POS_W      = MAX_TOKENS + 1;
  localparam int CNT_W      = $clog2(MAX_TOKENS + 1);
  localparam int IDX_W      = (MAX_TOKENS > 1) ? $clog2(MAX_TOKENS) : 1;
  localparam int LVL        = $clog2(POS_W);

  localparam logic [7:0] SYM_DOT = 8'h2E;  // '.'
  localparam logic [7:0] SYM_LO  = 8'h61;  // 'a'
  localparam logic [7:0] SYM_HI  = 8'h7A;  // 'z'

  typedef enum logic [1:0] {
    CMD_CLEAR   = 2'd0,
    CMD_APPEND  = 2'd1,
    CMD_RESTART = 2'd2,
    CMD_TEXT    = 2'd3
  } cmd_t;

  typedef struct packed {
    logic       starred;
    logic [7:0] symbol;
  } token_t;

  typedef struct packed {
    cmd_t       command;
    logic [7:0] symbol;
    logic       starred;
  } item_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [POS_W-1:0] active;
    logic             bad;
  } state_t;

  typedef struct packed {
    logic matched;
    logic pattern_full;
    logic pattern_bad;
  } result_t;

  // Star closure as a parallel prefix: position j is reached when some seed
  // position k <= j is set and every token k..j-1 is starred.
  function automatic logic [POS_W-1:0] star_close(input logic [POS_W-1:0]      seed,
                                                  input logic [MAX_TOKENS-1:0] pass);
    logic [POS_W-1:0] g;
    logic [POS_W-1:0] p;
    logic [POS_W-1:0] g_n;
    logic [POS_W-1:0] p_n;
    g = seed;
    p = {pass, 1'b0};
    for (int l = 0; l < LVL; l++) begin
      g_n = g;
      p_n = p;
      for (int j = 0; j < POS_W; j++) begin
        if (j >= (1 << l)) begin
          g_n[j] = g[j] | (p[j] & g[j - (1 << l)]);
          p_n[j] = p[j] & p[j - (1 << l)];
        end
      end
      g = g_n;
      p = p_n;
    end
    return g;
  endfunction

endpackage

FILE: hdl/dsm_channels.sv
// ----------------------------------------------------------------------------
// dsm channels - valid/ready interfaces for the pattern matcher
// Input item channel and result channel, each with source and sink views.
// ----------------------------------------------------------------------------
interface dsm_in_if;
  logic              valid;
  logic              ready;
  dsm_pkg::cmd_t     command;
  logic [7:0]        symbol;
  logic              starred;

  modport source (output valid, output command, output symbol, output starred,
                  input ready);
  modport sink   (input valid, input command, input symbol, input starred,
                  output ready);
endinterface

interface dsm_out_if;
  logic valid;
  logic ready;
  logic matched;
  logic pattern_full;
  logic pattern_bad;

  modport source (output valid, output matched, output pattern_full,
                  output pattern_bad, input ready);
  modport sink   (input valid, input matched, input pattern_full,
                  input pattern_bad, output ready);
endinterface

FILE: hdl/dsm_step.sv
// ----------------------------------------------------------------------------
// dsm_step - next-state logic of the position-set matcher
// Applies one item to the pattern state and forms its result.
// ----------------------------------------------------------------------------
module dsm_step (
  input  dsm_pkg::item_t  item,
  input  dsm_pkg::state_t state,
  input  dsm_pkg::token_t store [dsm_pkg::MAX_TOKENS],
  output dsm_pkg::state_t state_nxt,
  output dsm_pkg::result_t result,
  output logic            store_we
);
  import dsm_pkg::*;

  logic [MAX_TOKENS-1:0] en;
  logic [MAX_TOKENS-1:0] star;
  logic [MAX_TOKENS-1:0] hit;
  logic [MAX_TOKENS-1:0] star_app;
  logic [MAX_TOKENS-1:0] pass_n;
  logic [POS_W-1:0]      stepped;
  logic [POS_W-1:0]      seed;
  logic                  room;
  logic                  tok_ok;
  logic                  full;

  always_comb begin
    for (int i = 0; i < MAX_TOKENS; i++) begin
      en[i]       = CNT_W'(i) < state.count;
      star[i]     = en[i] & store[i].starred;
      hit[i]      = en[i] & state.active[i] &
                    ((store[i].symbol == SYM_DOT) || (store[i].symbol == item.symbol));
      star_app[i] = (CNT_W'(i) == state.count) ? item.starred : star[i];
    end
    // starred hit stays put, plain hit moves one position on
    stepped = {1'b0, hit & star} | {hit & ~star, 1'b0};
    room    = state.count < CNT_W'(MAX_TOKENS);
    tok_ok  = (item.symbol == SYM_DOT) ||
              ((item.symbol >= SYM_LO) && (item.symbol <= SYM_HI));

    state_nxt = state;
    full      = 1'b0;
    store_we  = 1'b0;
    pass_n    = star;
    seed      = state.active;
    unique case (item.command)
      CMD_CLEAR: begin
        state_nxt.count = '0;
        state_nxt.bad   = 1'b0;
        pass_n          = '0;
        seed            = POS_W'(1);
      end
      CMD_APPEND: begin
        if (room) begin
          store_we        = 1'b1;
          state_nxt.count = state.count + 1'b1;
          state_nxt.bad   = state.bad | ~tok_ok;
          pass_n          = star_app;
          seed            = POS_W'(1);
        end else begin
          full = 1'b1;
        end
      end
      CMD_RESTART: begin
        seed = POS_W'(1);
      end
      CMD_TEXT: begin
        seed = stepped;
      end
      default: begin
        seed = state.active;
      end
    endcase
    state_nxt.active = star_close(seed, pass_n);

    result.matched      = state_nxt.active[state_nxt.count] & ~state_nxt.bad;
    result.pattern_full = full;
    result.pattern_bad  = state_nxt.bad;
  end

endmodule

FILE: hdl/dot_star_pattern_match.sv
// ----------------------------------------------------------------------------
// dot_star_pattern_match - streaming whole-text pattern matcher
// Letter and '.' tokens, each optionally starred, matched over a byte text.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one item per handshake: command selects clear pattern,
//   append token (symbol, starred), start new text, or text byte (symbol).
//   out_ch returns exactly one result item per input item, in order:
//   matched (whole text so far matches whole pattern), pattern_full (this
//   append was dropped, store full) and pattern_bad (invalid token stored).
//   Timing: an accepted item is held in the input register, processed when
//   the result slot is free or being emptied, and its result is then held
//   in the result register that drives out_ch, where it waits until taken.
//   Throughput: one item per cycle unless out_ch stalls; the state update
//   (token compare, position shift, log-depth star closure) is combinational.
//   Reset (rst_n low, synchronous) empties the pattern, clears the bad flag
//   and leaves position zero active; token storage is not cleared.
//   When out_ch stalls, the result register holds and the input register
//   keeps one more item, after which in_ch.ready drops until the result is
//   taken.
// ----------------------------------------------------------------------------
module dot_star_pattern_match (
  input logic      clk,
  input logic      rst_n,
  dsm_in_if.sink   in_ch,
  dsm_out_if.source out_ch
);
  import dsm_pkg::*;

  // input register
  logic    in_valid_r;
  item_t   in_item_r;

  // pattern state
  state_t  state_r;
  state_t  state_nxt;
  token_t  store [MAX_TOKENS];

  // result register
  logic    out_valid_r;
  result_t out_res_r;
  result_t res_nxt;

  logic    store_we;
  logic    advance;

  // advance the held item when the result slot is free or being emptied
  assign advance     = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || advance;

  dsm_step u_step (
    .item      (in_item_r),
    .state     (state_r),
    .store     (store),
    .state_nxt (state_nxt),
    .result    (res_nxt),
    .store_we  (store_we)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_item_r <= '{command: in_ch.command, symbol: in_ch.symbol,
                     starred: in_ch.starred};
    end
  end

  // hold state until an item is processed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.count  <= '0;
      state_r.active <= POS_W'(1);
      state_r.bad    <= 1'b0;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  // token storage: only entries below the count are ever looked at
  always_ff @(posedge clk) begin
    if (advance && store_we) begin
      store[state_r.count[IDX_W-1:0]] <= '{starred: in_item_r.starred,
                                           symbol:  in_item_r.symbol};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.matched      = out_res_r.matched;
  assign out_ch.pattern_full = out_res_r.pattern_full;
  assign out_ch.pattern_bad  = out_res_r.pattern_bad;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.count <= CNT_W'(MAX_TOKENS))
    else $error("token count beyond capacity");

  a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
    advance && (in_item_r.command == CMD_APPEND) && (state_r.count < CNT_W'(MAX_TOKENS))
    |=> state_r.count == $past(state_r.count) + 1'b1)
    else $error("accepted append did not grow the pattern");

  a_clear_state: assert property (@(posedge clk) disable iff (!rst_n)
    advance && (in_item_r.command == CMD_CLEAR)
    |=> (state_r.count == '0) && !state_r.bad && (state_r.active == POS_W'(1)))
    else $error("clear left pattern state behind");

  a_bad_no_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.matched |-> !out_res_r.pattern_bad)
    else $error("match reported on a bad pattern");

  a_full_only_at_cap: assert property (@(posedge clk) disable iff (!rst_n)
    advance && res_nxt.pattern_full |=> $stable(state_r))
    else $error("dropped append changed the state");

endmodule
